// File: sv/decay_constant_estimator_assert.svh
// ----------------------------------------------------------------------------
// decay constant estimator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DECAY_CONSTANT_ESTIMATOR_ASSERT_SVH
`define DECAY_CONSTANT_ESTIMATOR_ASSERT_SVH
`ifndef SYNTH
`define DCE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dce assertion failed");
`define DCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dce sequence assertion failed");
`else
`define DCE_ASSERT(lbl, clk, rstn, prop)
`define DCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// shared constants, command and status types for the decay constant estimator
// ----------------------------------------------------------------------------
`default_nettype none

package dce_pkg;

    localparam int TRACE_LEN = 4096;
    localparam int ADDR_W    = $clog2(TRACE_LEN);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SMP_W     = 16;
    localparam int P_W       = 2 * ADDR_W;
    localparam int W_W       = 3 * ADDR_W + 3;
    localparam int PR_W      = W_W + SMP_W + 1;
    localparam int SUM_W     = 64;
    localparam int LOG_W     = 38;
    localparam int NUM_W     = 49;
    localparam int DEN_W     = 38;
    localparam int DVD_W     = 51;
    localparam int REM_W     = DEN_W + 1;
    localparam int TAU_W     = 48;

    localparam logic [15:0]      CLK_PERIOD_RST = 16'd4000;
    localparam logic [32:0]      LOG2E_Q32      = 33'd6196328019;
    localparam logic [15:0]      RECIP10        = 16'd6554;
    localparam logic [5:0]       LOG_E_MAX      = 6'd63;
    localparam logic [4:0]       LOG_BITS_LAST  = 5'd31;
    localparam logic [5:0]       DIV_STEPS_LAST = 6'(DVD_W - 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOT_POS = 2'd2,
        ST_ONE     = 2'd3
    } dce_status_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SETUP,
        S_PREF,
        S_SUM_A,
        S_SUM_B,
        S_SUM_C,
        S_SUM_D,
        S_CHECK,
        S_LOG_INIT,
        S_LOG_INIT_B,
        S_LOG_NORM,
        S_LOG_SQ,
        S_LOG_FIX,
        S_DIV_INIT,
        S_DIV_PREP,
        S_DIV_STEP,
        S_FIN,
        S_OUT
    } dce_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic pref;
        logic sum_a;
        logic sum_b;
        logic sum_c;
        logic sum_d;
        logic check;
        logic log_init;
        logic log_b;
        logic log_norm;
        logic log_sq;
        logic log_fix;
        logic div_init;
        logic div_prep;
        logic div_step;
        logic fin;
        logic out_load;
    } dce_cmd_t;

    typedef struct packed {
        logic last_k;
        logic n_le1;
        logic status_nz;
        logic log_normed;
        logic log_done;
        logic log_is_b;
        logic den_zero;
        logic div_done;
    } dce_sts_t;

endpackage

`default_nettype wire

// File: sv/dce_dpath.sv
// ----------------------------------------------------------------------------
// dce_dpath
// trace memory, peak/valley tracking, weighted sums, log2 unit and divider
// ----------------------------------------------------------------------------
`default_nettype none
`include "decay_constant_estimator_assert.svh"

module dce_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dce_pkg::dce_cmd_t             cmd,
    output dce_pkg::dce_sts_t                  sts,
    input  wire logic [15:0]                   s_sample,
    input  wire logic                          cfg_wr_en,
    input  wire logic [15:0]                   cfg_wr_data,
    output logic signed [dce_pkg::TAU_W-1:0]   m_tau_ps,
    output logic [1:0]                         m_status
);
    import dce_pkg::*;

    logic [SMP_W-1:0]  mem [TRACE_LEN];
    logic [SMP_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [15:0]       clk_period_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] peak_reg, valley_reg;
    logic [SMP_W-1:0]  peak_val_reg, valley_val_reg;
    logic              in_range;
    logic [ADDR_W-1:0] idx;

    logic [ADDR_W-1:0]    d_val, t_val;
    logic [ADDR_W+15:0]   t_full;
    logic [ADDR_W-1:0]    n_reg, start_reg, k_reg;
    logic [SMP_W-1:0]     xprev_reg;
    logic [P_W-1:0]       p_reg;
    logic signed [ADDR_W+1:0] nm2k;
    logic signed [W_W-1:0]  w_reg, w_next;
    logic signed [PR_W-1:0] prod1_reg, prod2_reg, prod1_next, prod2_next;
    logic signed [SUM_W-1:0] s1_reg, s2_reg;

    dce_status_t       status_reg, status_next;
    logic [SUM_W-1:0]  a_reg, b_reg;

    logic [SUM_W-1:0]  lx_reg;
    logic [5:0]        e_reg;
    logic [31:0]       m_reg, frac_reg, frac_next;
    logic [63:0]       sq_reg;
    logic [4:0]        bcnt_reg;
    logic              log_is_b_reg;
    logic [LOG_W-1:0]  la_reg, lb_reg;

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W:0]    rem_sh, dsr;
    logic              ge;
    logic [5:0]        dcnt_reg;

    logic [DVD_W-1:0]  mag;
    logic [TAU_W-1:0]  tau_sat;
    logic [TAU_W-1:0]  tau_res_reg;

    // trace memory
    assign idx      = cnt_reg[ADDR_W-1:0];
    assign in_range = cnt_reg < CNT_W'(TRACE_LEN);
    assign rd_addr  = start_reg + k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && in_range) begin
            mem[idx] <= s_sample;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_period_reg <= CLK_PERIOD_RST;
        end else if (cfg_wr_en) begin
            clk_period_reg <= cfg_wr_data;
        end
    end

    // sample count and extremum tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.setup) begin
            cnt_reg <= '0;
        end else if (cmd.load && in_range) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && in_range) begin
            if (cnt_reg == '0 || s_sample > peak_val_reg) begin
                peak_reg       <= idx;
                valley_reg     <= idx;
                peak_val_reg   <= s_sample;
                valley_val_reg <= s_sample;
            end else if (s_sample < valley_val_reg) begin
                valley_reg     <= idx;
                valley_val_reg <= s_sample;
            end
        end
    end

    // window setup and weighted sums
    assign d_val  = valley_reg - peak_reg;
    assign t_full = (ADDR_W+16)'(d_val) * (ADDR_W+16)'(RECIP10);
    assign t_val  = t_full[ADDR_W+15:16];
    assign nm2k   = $signed({2'b00, n_reg}) - $signed({1'b0, k_reg, 1'b0});
    assign w_next = W_W'($signed({1'b0, p_reg})) * W_W'(nm2k);
    assign prod1_next = PR_W'($signed({1'b0, xprev_reg})) * PR_W'(w_reg);
    assign prod2_next = PR_W'($signed({1'b0, rdata_reg})) * PR_W'(w_reg);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            n_reg     <= d_val - {t_val[ADDR_W-2:0], 1'b0};
            start_reg <= peak_reg + t_val;
            k_reg     <= '0;
            s1_reg    <= '0;
            s2_reg    <= '0;
        end
        if (cmd.pref) begin
            k_reg <= ADDR_W'(1);
        end
        if (cmd.sum_a) begin
            xprev_reg <= rdata_reg;
            p_reg     <= P_W'(k_reg) * P_W'(n_reg - k_reg);
        end
        if (cmd.sum_b) begin
            w_reg <= w_next;
        end
        if (cmd.sum_c) begin
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
        if (cmd.sum_d) begin
            s1_reg <= s1_reg + SUM_W'(prod1_reg);
            s2_reg <= s2_reg + SUM_W'(prod2_reg);
            k_reg  <= k_reg + 1'b1;
        end
    end

    // ratio checks
    always_comb begin
        if (n_reg == '0) begin
            status_next = ST_EMPTY;
        end else if (s1_reg == '0 || s2_reg == '0 || s1_reg[SUM_W-1] != s2_reg[SUM_W-1]) begin
            status_next = ST_NOT_POS;
        end else if (s1_reg == s2_reg) begin
            status_next = ST_ONE;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            status_reg <= status_next;
            a_reg      <= s1_reg[SUM_W-1] ? SUM_W'(-s1_reg) : SUM_W'(s1_reg);
            b_reg      <= s2_reg[SUM_W-1] ? SUM_W'(-s2_reg) : SUM_W'(s2_reg);
        end
    end

    // log2 unit, shared by both sums
    assign frac_next = {frac_reg[30:0], sq_reg[63]};

    always_ff @(posedge aclk) begin
        if (cmd.log_init) begin
            lx_reg       <= cmd.log_b ? b_reg : a_reg;
            e_reg        <= LOG_E_MAX;
            log_is_b_reg <= cmd.log_b;
        end
        if (cmd.log_norm) begin
            if (lx_reg[SUM_W-1]) begin
                m_reg    <= lx_reg[SUM_W-1:SUM_W-32];
                frac_reg <= '0;
                bcnt_reg <= '0;
            end else begin
                lx_reg <= {lx_reg[SUM_W-2:0], 1'b0};
                e_reg  <= e_reg - 1'b1;
            end
        end
        if (cmd.log_sq) begin
            sq_reg <= 64'(m_reg) * 64'(m_reg);
        end
        if (cmd.log_fix) begin
            m_reg    <= sq_reg[63] ? sq_reg[63:32] : sq_reg[62:31];
            frac_reg <= frac_next;
            bcnt_reg <= bcnt_reg + 1'b1;
            if (bcnt_reg == LOG_BITS_LAST) begin
                if (log_is_b_reg) begin
                    lb_reg <= {e_reg, frac_next};
                end else begin
                    la_reg <= {e_reg, frac_next};
                end
            end
        end
    end

    // divider, one quotient bit per cycle
    assign dsr    = {1'b0, den_reg, 1'b0};
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= dsr;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg <= (la_reg < lb_reg) || (a_reg < b_reg);
            den_reg <= (la_reg < lb_reg) ? lb_reg - la_reg : la_reg - lb_reg;
            num_reg <= NUM_W'(clk_period_reg) * NUM_W'(LOG2E_Q32);
        end
        if (cmd.div_prep) begin
            dvd_reg  <= {1'b0, num_reg, 1'b0} + DVD_W'(den_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= ge ? REM_W'(rem_sh - dsr) : REM_W'(rem_sh);
            dvd_reg  <= {dvd_reg[DVD_W-2:0], ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // rounding done, saturate and sign
    always_comb begin
        mag = (den_reg == '0) ? (DVD_W'(1) << (TAU_W - 1)) : dvd_reg;
        if (neg_reg) begin
            if (mag > (DVD_W'(1) << (TAU_W - 1))) begin
                tau_sat = {1'b1, {(TAU_W-1){1'b0}}};
            end else begin
                tau_sat = TAU_W'(-mag);
            end
        end else begin
            if (mag > DVD_W'({1'b0, {(TAU_W-1){1'b1}}})) begin
                tau_sat = {1'b0, {(TAU_W-1){1'b1}}};
            end else begin
                tau_sat = mag[TAU_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            tau_res_reg <= (status_reg != ST_OK) ? '0 : tau_sat;
        end
        if (cmd.out_load) begin
            m_tau_ps <= $signed(tau_res_reg);
            m_status <= status_reg;
        end
    end

    assign sts.last_k     = (k_reg == n_reg - 1'b1);
    assign sts.n_le1      = (n_reg <= ADDR_W'(1));
    assign sts.status_nz  = (status_reg != ST_OK);
    assign sts.log_normed = lx_reg[SUM_W-1];
    assign sts.log_done   = (bcnt_reg == LOG_BITS_LAST);
    assign sts.log_is_b   = log_is_b_reg;
    assign sts.den_zero   = (den_reg == '0);
    assign sts.div_done   = (dcnt_reg == DIV_STEPS_LAST);

    `DCE_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(TRACE_LEN))
    `DCE_ASSERT(a_k_window, aclk, aresetn, cmd.sum_a |-> (k_reg != '0 && k_reg < n_reg))
    `DCE_ASSERT(a_m_normed, aclk, aresetn, cmd.log_sq |-> m_reg[31])

endmodule

`default_nettype wire

// File: sv/dce_ctrl.sv
// ----------------------------------------------------------------------------
// dce_ctrl
// sequencer for load, window sweep, log2, divide and result handoff
// ----------------------------------------------------------------------------
`default_nettype none
`include "decay_constant_estimator_assert.svh"

module dce_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_last_sample,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dce_pkg::dce_cmd_t       cmd,
    input  wire dce_pkg::dce_sts_t  sts
);
    import dce_pkg::*;

    dce_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last_sample) begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_PREF;
            end
            S_PREF: begin
                cmd.pref   = 1'b1;
                state_next = sts.n_le1 ? S_CHECK : S_SUM_A;
            end
            S_SUM_A: begin
                cmd.sum_a  = 1'b1;
                state_next = S_SUM_B;
            end
            S_SUM_B: begin
                cmd.sum_b  = 1'b1;
                state_next = S_SUM_C;
            end
            S_SUM_C: begin
                cmd.sum_c  = 1'b1;
                state_next = S_SUM_D;
            end
            S_SUM_D: begin
                cmd.sum_d  = 1'b1;
                state_next = sts.last_k ? S_CHECK : S_SUM_A;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_LOG_INIT;
            end
            S_LOG_INIT: begin
                if (sts.status_nz) begin
                    state_next = S_FIN;
                end else begin
                    cmd.log_init = 1'b1;
                    state_next   = S_LOG_NORM;
                end
            end
            S_LOG_INIT_B: begin
                cmd.log_init = 1'b1;
                cmd.log_b    = 1'b1;
                state_next   = S_LOG_NORM;
            end
            S_LOG_NORM: begin
                cmd.log_norm = 1'b1;
                if (sts.log_normed) begin
                    state_next = S_LOG_SQ;
                end
            end
            S_LOG_SQ: begin
                cmd.log_sq = 1'b1;
                state_next = S_LOG_FIX;
            end
            S_LOG_FIX: begin
                cmd.log_fix = 1'b1;
                if (!sts.log_done) begin
                    state_next = S_LOG_SQ;
                end else if (sts.log_is_b) begin
                    state_next = S_DIV_INIT;
                end else begin
                    state_next = S_LOG_INIT_B;
                end
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV_PREP;
            end
            S_DIV_PREP: begin
                cmd.div_prep = 1'b1;
                state_next   = sts.den_zero ? S_FIN : S_DIV_STEP;
            end
            S_DIV_STEP: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

    `DCE_ASSERT(a_out_free, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_ready))
    `DCE_ASSERT_NEXT(a_last_setup, aclk, aresetn, s_valid && s_ready && s_last_sample, state_reg == S_SETUP)
    `DCE_ASSERT_NEXT(a_div_fin, aclk, aresetn, state_reg == S_DIV_STEP && sts.div_done, state_reg == S_FIN)

endmodule

`default_nettype wire

// File: sv/decay_constant_estimator.sv
// ----------------------------------------------------------------------------
// decay_constant_estimator
// loads a trace, then estimates its exponential decay time in picoseconds
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_sample[15:0], s_last_sample
// m_        out        m_valid/m_ready    m_tau_ps[47:0] signed, m_status[1:0]
// cfg_      in         cfg_wr_en          cfg_wr_data[15:0] clock period in ps
//
// samples load one per cycle while s_ready is high into a 4096 x 16 trace memory
// after the last sample: setup, then a sweep over the window samples, then
// a log2 pass for each of the two sums (normalize, then square/fix), then the divide
// s_ready is low from the last sample until the request is in the output register
// a pending output request does not block loading of the next trace
// reset clears control state, the sample count and the clock period setting; the trace memory needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module decay_constant_estimator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [15:0]                 s_sample,
    input  wire logic                        s_last_sample,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [dce_pkg::TAU_W-1:0] m_tau_ps,
    output logic [1:0]                       m_status,
    input  wire logic                        cfg_wr_en,
    input  wire logic [15:0]                 cfg_wr_data
);
    import dce_pkg::*;

    dce_cmd_t cmd;
    dce_sts_t sts;

    dce_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd),
        .sts           (sts)
    );

    dce_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_sample    (s_sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tau_ps    (m_tau_ps),
        .m_status    (m_status)
    );

endmodule

`default_nettype wire

// File: verif/dce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_checker
// watches the sample, result and clock period ports of the decay constant
// estimator, keeps its own trace copy, predicts each decay time and status
// and compares every result request against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module dce_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [15:0] s_sample,
    input  wire logic        s_last_sample,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [47:0] m_tau_ps,
    input  wire logic [1:0]  m_status,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    output int               outstanding,
    output int               errors
);
    import dce_pkg::*;

    localparam longint unsigned LN2_INV_Q32 = 64'd6196328019;
    localparam longint unsigned TAU_POS_LIM = 64'd140737488355327;
    localparam longint unsigned TAU_NEG_LIM = 64'd140737488355328;

    typedef struct {
        logic [47:0] tau;
        dce_status_t status;
    } decay_result_t;

    decay_result_t decay_q[$];
    logic [15:0]   trace_mem [TRACE_LEN];
    int unsigned   sample_cnt;
    int unsigned   peak_at;
    int unsigned   valley_at;
    logic [15:0]   period_ps;

    function automatic longint signed weight_of(longint signed k, longint signed n);
        return k * (n - k) * (n - 2 * k);
    endfunction

    function automatic longint unsigned log2_fix(longint unsigned x);
        int                   e;
        longint unsigned      m;
        longint unsigned      frac;
        e = 63;
        frac = 0;
        while (e > 0 && x[e] == 1'b0) e--;
        if (e >= 31) m = x >> (e - 31);
        else m = x << (31 - e);
        for (int b = 0; b < 32; b++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (longint'(e) << 32) | frac;
    endfunction

    function automatic decay_result_t estimate_decay();
        decay_result_t   r;
        int unsigned     d, t, start, n, pos;
        longint signed   s_next, s_this, v;
        longint unsigned a, b, la, lb, den, mag, num;
        bit              neg;
        r.tau = '0;
        r.status = ST_OK;
        d = valley_at - peak_at;
        t = d / 10;
        start = peak_at + t;
        n = d - 2 * t;
        s_next = 0;
        s_this = 0;
        for (int unsigned i = 0; i < n; i++) begin
            pos = start + i;
            v = (pos < TRACE_LEN) ? longint'(trace_mem[pos]) : 0;
            s_next += v * weight_of(i + 1, n);
            s_this += v * weight_of(i, n);
        end
        if (n == 0) begin
            r.status = ST_EMPTY;
        end else if (s_next == 0 || s_this == 0 || ((s_next < 0) != (s_this < 0))) begin
            r.status = ST_NOT_POS;
        end else if (s_next == s_this) begin
            r.status = ST_ONE;
        end else begin
            a = s_next < 0 ? -s_next : s_next;
            b = s_this < 0 ? -s_this : s_this;
            la = log2_fix(a);
            lb = log2_fix(b);
            neg = la < lb;
            den = neg ? lb - la : la - lb;
            if (a < b) neg = 1'b1;
            if (den == 0) begin
                mag = TAU_NEG_LIM;
            end else begin
                num = longint'(period_ps) * LN2_INV_Q32;
                mag = (2 * num + den) / (2 * den);
            end
            if (neg) begin
                if (mag > TAU_NEG_LIM) mag = TAU_NEG_LIM;
                r.tau = 48'(-mag);
            end else begin
                if (mag > TAU_POS_LIM) mag = TAU_POS_LIM;
                r.tau = 48'(mag);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        decay_result_t got;
        if (!aresetn) begin
            decay_q.delete();
            sample_cnt = 0;
            peak_at = 0;
            valley_at = 0;
            period_ps = CLK_PERIOD_RST;
            errors = 0;
        end else begin
            if (cfg_wr_en) period_ps = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (sample_cnt < TRACE_LEN) begin
                    trace_mem[sample_cnt] = s_sample;
                    if (sample_cnt == 0 || s_sample > trace_mem[peak_at]) begin
                        peak_at = sample_cnt;
                        valley_at = sample_cnt;
                    end else if (s_sample < trace_mem[valley_at]) begin
                        valley_at = sample_cnt;
                    end
                    sample_cnt++;
                end
                if (s_last_sample) begin
                    decay_q.push_back(estimate_decay());
                    sample_cnt = 0;
                    peak_at = 0;
                    valley_at = 0;
                end
            end
            if (m_valid && m_ready) begin
                if (decay_q.size() == 0) begin
                    $error("unexpected result request tau_ps %0d status %0d",
                           $signed(m_tau_ps), m_status);
                    errors++;
                end else begin
                    got = decay_q.pop_front();
                    if (m_tau_ps !== got.tau) begin
                        $error("tau_ps expected %0d actual %0d",
                               $signed(got.tau), $signed(m_tau_ps));
                        errors++;
                    end
                    if (m_status !== got.status) begin
                        $error("status expected %0d actual %0d", got.status, m_status);
                        errors++;
                    end
                end
            end
        end
        outstanding = decay_q.size();
    end

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// decay constant estimator testbench: directed traces for the empty window
// and non-positive cases, then random decay pulses and noise
// traces under several clock periods, with random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import dce_pkg::*;

    localparam int WATCHDOG_LIM = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample = '0;
    logic        s_last_sample = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [TAU_W-1:0] m_tau_ps;
    logic [1:0]  m_status;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    int          outstanding;
    int          errors;
    int          sent_cnt = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;
    bit          hold_off = 1'b0;
    bit          pressure_done = 1'b0;
    logic [15:0] trace_q[$];

    always #2 aclk = ~aclk;

    decay_constant_estimator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tau_ps      (m_tau_ps),
        .m_status      (m_status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    dce_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tau_ps      (m_tau_ps),
        .m_status      (m_status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .outstanding   (outstanding),
        .errors        (errors)
    );

    // watchdog on cycles without any accepted request
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIM) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // result side
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                stall = 400;
                hold_off = 1'b0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_sample(input logic [15:0] smp, input bit lst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_last_sample <= lst;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
    endtask

    task automatic send_trace();
        for (int i = 0; i < trace_q.size(); i++) send_sample(trace_q[i], i == trace_q.size() - 1);
        s_valid <= 1'b0;
        trace_q.delete();
        @(posedge aclk);
    endtask

    task automatic make_pulse();
        int unsigned amp, base, shift, len, val, lvl;
        amp = $urandom_range(500, 65535);
        base = $urandom_range(0, 300);
        shift = $urandom_range(1, 5);
        len = $urandom_range(6, 60);
        repeat ($urandom_range(0, 4)) trace_q.push_back(16'($urandom_range(0, base)));
        val = amp;
        for (int i = 0; i < len; i++) begin
            lvl = base + val + $urandom_range(0, 3);
            trace_q.push_back(lvl > 65535 ? 16'hffff : 16'(lvl));
            val = val - (val >> shift);
        end
        if ($urandom_range(0, 1)) trace_q.push_back(16'($urandom_range(0, base)));
    endtask

    task automatic make_noise(input int len);
        repeat (len) trace_q.push_back(16'($urandom));
    endtask

    task automatic set_period(input logic [15:0] ps);
        wait (outstanding == 0);
        repeat (60) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ps;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [15:0] periods [4];
        periods = '{16'd1, 16'd65535, 16'd0, 16'd4000};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single sample: empty window
        trace_q = '{16'hffff};
        send_trace();
        // flat trace: empty window
        trace_q = '{16'd0, 16'd0, 16'd0};
        send_trace();
        // zero window sum: not positive
        trace_q = '{16'd100, 16'd0, 16'd0};
        send_trace();
        // constant window: weighted sums are zero, not positive
        trace_q = '{16'd100, 16'd50, 16'd50, 16'd50, 16'd50, 16'd50, 16'd50,
                    16'd50, 16'd50, 16'd50, 16'd50, 16'd10};
        send_trace();
        make_pulse();
        send_trace();

        set_period(16'd4000);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) set_period(periods[ph]);
            else set_period(16'($urandom_range(1, 65535)));
            while (sent_cnt < 390 * (ph + 1)) begin
                steady = ($urandom_range(0, 9) == 0);
                if (ph == 1 && !pressure_done && sent_cnt > 500) begin
                    hold_off = 1'b1;
                    pressure_done = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1:    make_noise($urandom_range(1, 20));
                    2:       make_noise($urandom_range(1, 3));
                    default: make_pulse();
                endcase
                send_trace();
            end
        end
        steady = 1'b0;

        wait (outstanding == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/dce_pkg.sv
sv/dce_dpath.sv
sv/dce_ctrl.sv
sv/decay_constant_estimator.sv
verif/dce_checker.sv
verif/tb.sv
